### rtl/time_bucket_statistics_ring_defines.svh
// ----------------------------------------------------------------------------
// time_bucket_statistics_ring_defines
// Assertion macros for the bucket ring.
// ----------------------------------------------------------------------------
`ifndef TIME_BUCKET_STATISTICS_RING_DEFINES_SVH
`define TIME_BUCKET_STATISTICS_RING_DEFINES_SVH
// assert that a implies b on the next clock
`define TBSR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
// assert that a implies b in the same clock
`define TBSR_ASSERT_NOW(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`endif

### rtl/tbsr_pkg.sv
// ----------------------------------------------------------------------------
// tbsr_pkg
// Shared types and constants of the time bucket ring.
// ----------------------------------------------------------------------------
package tbsr_pkg;
	localparam int unsigned MAX_BUCKETS_DEF = 64;
	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;
	localparam logic CFG_PERIOD  = 1'b0;
	localparam logic CFG_BUCKETS = 1'b1;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;
endpackage

### rtl/tbsr_div.sv
// ----------------------------------------------------------------------------
// tbsr_div
// Restoring divider, one quotient bit per cycle through a shift register.
// ----------------------------------------------------------------------------
module tbsr_div import tbsr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);
	logic [31:0] quo_q, rem_q, dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q, done_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				quo_q  <= req.dividend;
				rem_q  <= '0;
				dvs_q  <= req.divisor;
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.busy      = busy_q;
	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;
endmodule

### rtl/tbsr_ram.sv
// ----------------------------------------------------------------------------
// tbsr_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module tbsr_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

### rtl/time_bucket_statistics_ring.sv
// ----------------------------------------------------------------------------
// time_bucket_statistics_ring
// Ring of time buckets holding sum, count, min and max of samples.
// ----------------------------------------------------------------------------
// One item at a time. An item holds the input channel from the accepting edge
// to the next possible one: the bit-serial divide timestamp / period_length
// (32 quotient bits plus the done cycle), a second pass of the same divider
// giving period mod bucket count, the bucket RAM read, read wait and
// writeback, and the return to idle. A query result is loaded into an output
// register at writeback and sits there until taken; while it waits the input
// stalls. After reset a clearing pass writes every bucket count to zero,
// during which no item is taken; configuration writes are taken at all times.
`include "time_bucket_statistics_ring_defines.svh"
module time_bucket_statistics_ring import tbsr_pkg::*; #(
	parameter int unsigned MAX_BUCKETS = MAX_BUCKETS_DEF,
	localparam int unsigned AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write transaction
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic signed [31:0] value,
	input  logic [31:0]        timestamp,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               found,
	output logic signed [63:0] total,
	output logic [31:0]        sample_count,
	output logic signed [31:0] smallest,
	output logic signed [31:0] largest,
	output logic [31:0]        period_number
);
	typedef enum logic [2:0] {
		S_CLEAR, S_IDLE, S_DIV1, S_DIV2, S_READ, S_WAIT, S_WRITE
	} state_t;

	state_t      state_q;
	logic [31:0] period_q;
	logic [6:0]  nbuck_q;
	logic        op_q;
	logic [31:0] val_q, pnum_q;
	logic [AW-1:0] slot_q;
	logic [AW:0] clr_q;
	div_req_t    dreq;
	div_rsp_t    drsp;
	logic        started_q;

	// ring size clamped to 1..MAX_BUCKETS
	logic [31:0] eff_n;
	always_comb begin
		eff_n = {25'd0, nbuck_q};
		if (nbuck_q == 7'd0) eff_n = 32'd1;
		if (eff_n > 32'(MAX_BUCKETS)) eff_n = 32'(MAX_BUCKETS);
	end

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 32'd1;
			nbuck_q  <= 7'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PERIOD:  period_q <= cfg_data;
				CFG_BUCKETS: nbuck_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	logic in_acc;
	assign in_acc = in_valid && !in_stall;

	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = timestamp;
		dreq.divisor  = (period_q == 32'd0) ? 32'd1 : period_q;
		if (in_acc) dreq.start = 1'b1;
		else if (state_q == S_DIV1 && drsp.done) begin
			dreq.start    = 1'b1;
			dreq.dividend = drsp.quotient;
			dreq.divisor  = eff_n;
		end
	end

	tbsr_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// bucket RAMs
	logic          we;
	logic [AW-1:0] addr;
	logic [31:0]   tag_w, tag_r, cnt_w, cnt_r, min_w, min_r, max_w, max_r;
	logic [63:0]   sum_w, sum_r;

	assign addr = (state_q == S_CLEAR) ? clr_q[AW-1:0] : slot_q;

	tbsr_ram #(.WIDTH(32), .DEPTH(MAX_BUCKETS)) u_tag
		(.clk(clk), .we(we), .addr(addr), .wdata(tag_w), .rdata(tag_r));
	tbsr_ram #(.WIDTH(64), .DEPTH(MAX_BUCKETS)) u_sum
		(.clk(clk), .we(we), .addr(addr), .wdata(sum_w), .rdata(sum_r));
	tbsr_ram #(.WIDTH(32), .DEPTH(MAX_BUCKETS)) u_cnt
		(.clk(clk), .we(we), .addr(addr), .wdata(cnt_w), .rdata(cnt_r));
	tbsr_ram #(.WIDTH(32), .DEPTH(MAX_BUCKETS)) u_min
		(.clk(clk), .we(we), .addr(addr), .wdata(min_w), .rdata(min_r));
	tbsr_ram #(.WIDTH(32), .DEPTH(MAX_BUCKETS)) u_max
		(.clk(clk), .we(we), .addr(addr), .wdata(max_w), .rdata(max_r));

	// update of the bucket
	logic live;
	assign live = (cnt_r != 32'd0) && (tag_r == pnum_q);
	always_comb begin
		we    = 1'b0;
		tag_w = pnum_q;
		sum_w = {{32{val_q[31]}}, val_q};
		cnt_w = 32'd1;
		min_w = val_q;
		max_w = val_q;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			cnt_w = 32'd0;
			tag_w = 32'd0;
			sum_w = 64'd0;
		end else if (state_q == S_WRITE && op_q == OP_ADD) begin
			we = 1'b1;
			if (live) begin
				sum_w = sum_r + {{32{val_q[31]}}, val_q};
				cnt_w = (cnt_r == 32'hFFFF_FFFF) ? cnt_r : cnt_r + 32'd1;
				min_w = ($signed(val_q) < $signed(min_r)) ? val_q : min_r;
				max_w = ($signed(max_r) < $signed(val_q)) ? val_q : max_r;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_q     <= '0;
			out_valid <= 1'b0;
			started_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + (AW+1)'(1);
					if (clr_q == (AW+1)'(MAX_BUCKETS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: if (in_acc) begin
					op_q    <= op;
					val_q   <= value;
					state_q <= S_DIV1;
					started_q <= 1'b1;
				end
				S_DIV1: if (drsp.done) begin
					pnum_q  <= drsp.quotient;
					state_q <= S_DIV2;
				end
				S_DIV2: if (drsp.done) begin
					slot_q  <= drsp.remainder[AW-1:0];
					state_q <= S_READ;
				end
				S_READ:  state_q <= S_WAIT;
				S_WAIT:  state_q <= S_WRITE;
				S_WRITE: begin
					if (op_q == OP_QUERY) begin
						out_valid     <= 1'b1;
						found         <= live;
						total         <= live ? sum_r : 64'd0;
						sample_count  <= live ? cnt_r : 32'd0;
						smallest      <= live ? min_r : 32'd0;
						largest       <= live ? max_r : 32'd0;
						period_number <= pnum_q;
					end
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TBSR_ASSERT_NOW(a_no_take_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`TBSR_ASSERT_NOW(a_div_idle, clk, arst_n, state_q == S_IDLE && started_q, !drsp.busy)
	`TBSR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
endmodule
